// ===== sv/fan_curve_interpolator_unit_defines.svh =====
// Assertion macros shared by the fan curve interpolator RTL.
`ifndef FAN_CURVE_INTERPOLATOR_UNIT_DEFINES_SVH
`define FAN_CURVE_INTERPOLATOR_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define FCI_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define FCI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/fci_pkg.sv =====
// Shared types and constants of the fan curve interpolator.
package fci_pkg;

  localparam int NUM_REGS       = 8;
  localparam int CURVE_POINTS_DEF = 8;
  localparam int CFG_IDX_W      = 3;
  localparam int POINT_W        = 15;
  localparam int TEMP_IN_W      = 9;
  localparam int PCT_W          = 7;
  localparam int PT_TEMP_W      = 7;

  localparam logic [PCT_W-1:0]     PCT_MAX  = 7'd100;
  localparam logic [PT_TEMP_W-1:0] TEMP_MAX = 7'd100;

  localparam logic [POINT_W-1:0] POINT_RESET [NUM_REGS] = '{
    15'd5181, 15'd9051, 15'd14201, 15'd18577,
    15'd23209, 15'd24500, 15'd25790, 15'd25800
  };

  // Divider: dividend magnitude, divisor (span) and quotient bits per stage.
  localparam int DIV_NUM_W = 16;
  localparam int DIV_DEN_W = 7;
  localparam int DIV_BPS   = 4;

  typedef struct packed {
    logic [PT_TEMP_W-1:0] temp;
    logic [PCT_W-1:0]     pct;
  } curve_pt_t;

  typedef struct packed {
    logic             direct;
    logic [PCT_W-1:0] lp;
  } div_tag_t;

endpackage

// ===== sv/fci_sorter.sv =====
// Curve point gather and exchange sort, rerun after reset and each register write.
module fci_sorter import fci_pkg::*; #(
  parameter int CURVE_POINTS = CURVE_POINTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [POINT_W-1:0]                points [NUM_REGS],
  output curve_pt_t                         pts [CURVE_POINTS],
  output logic [$clog2(CURVE_POINTS+1)-1:0] cnt,
  output logic                              busy
);

  localparam int IDX_W = $clog2(CURVE_POINTS);
  localparam int CNT_W = $clog2(CURVE_POINTS+1);

  typedef enum logic [1:0] {SORT_IDLE, SORT_LOAD, SORT_ROTATE, SORT_COMMIT} sort_state_t;

  sort_state_t      state;
  curve_pt_t        ring [CURVE_POINTS];
  curve_pt_t        head;
  logic [IDX_W-1:0] pass_i;
  logic [IDX_W-1:0] step_k;

  curve_pt_t        load_ring [CURVE_POINTS];
  logic [CNT_W-1:0] load_cnt;
  curve_pt_t        front;
  curve_pt_t        push;
  logic             is_head;
  logic             take;

  // Pack enabled points to the front in index order.
  always_comb begin
    for (int i = 0; i < CURVE_POINTS; i++) load_ring[i] = '0;
    load_cnt = '0;
    for (int i = 0; i < CURVE_POINTS; i++) begin
      if (points[i][0]) begin
        load_ring[load_cnt[IDX_W-1:0]] = '{temp: points[i][7:1], pct: points[i][14:8]};
        load_cnt = load_cnt + 1'b1;
      end
    end
  end

  // Ring front is position step_k; head holds the running pick for position pass_i.
  always_comb begin
    front   = ring[0];
    is_head = (step_k == pass_i);
    take    = (step_k > pass_i) && (CNT_W'(step_k) < cnt) && (front.temp < head.temp);
    push    = take ? head : front;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= SORT_LOAD;
      pass_i <= '0;
      step_k <= '0;
      cnt    <= '0;
    end else if (start) begin
      state <= SORT_LOAD;
    end else begin
      case (state)
        SORT_LOAD: begin
          ring   <= load_ring;
          cnt    <= load_cnt;
          pass_i <= '0;
          step_k <= '0;
          state  <= SORT_ROTATE;
        end
        SORT_ROTATE: begin
          for (int m = 0; m < CURVE_POINTS - 1; m++) ring[m] <= ring[m+1];
          ring[CURVE_POINTS-1] <= push;
          if (is_head || take) head <= front;
          if (step_k == IDX_W'(CURVE_POINTS - 1)) begin
            step_k <= '0;
            state  <= SORT_COMMIT;
          end else begin
            step_k <= step_k + 1'b1;
          end
        end
        SORT_COMMIT: begin
          ring[pass_i] <= head;
          if (pass_i == IDX_W'(CURVE_POINTS - 1)) begin
            state <= SORT_IDLE;
          end else begin
            pass_i <= pass_i + 1'b1;
            state  <= SORT_ROTATE;
          end
        end
        default: state <= SORT_IDLE;
      endcase
    end
  end

  assign pts  = ring;
  assign busy = (state != SORT_IDLE);

endmodule

// ===== sv/fci_div_pipe.sv =====
// Pipelined restoring divider, a few quotient bits per stage, with a side tag.
module fci_div_pipe import fci_pkg::*; #(
  parameter int NUM_W = DIV_NUM_W,
  parameter int DEN_W = DIV_DEN_W,
  parameter int BPS   = DIV_BPS
) (
  input  logic                 clk,
  input  logic [NUM_W/BPS-1:0] en,
  input  logic [NUM_W-1:0]     num,
  input  logic [DEN_W-1:0]     den,
  input  logic                 neg_in,
  input  div_tag_t             tag_in,
  output logic [NUM_W-1:0]     quo,
  output logic                 neg_out,
  output div_tag_t             tag_out
);

  localparam int STAGES = NUM_W / BPS;

  logic [DEN_W:0]   rem_q [STAGES];
  logic [NUM_W-1:0] dq_q  [STAGES];
  logic [DEN_W-1:0] den_q [STAGES];
  logic             neg_q [STAGES];
  div_tag_t         tag_q [STAGES];

  logic [DEN_W:0]   rem_in [STAGES];
  logic [NUM_W-1:0] dq_in  [STAGES];
  logic [DEN_W-1:0] den_in [STAGES];
  logic             neg_i  [STAGES];
  div_tag_t         tag_i  [STAGES];

  // Shift dividend bits into the remainder; quotient bits fill in from the bottom.
  function automatic logic [DEN_W+NUM_W:0] div_step(
    input logic [DEN_W:0]   rem,
    input logic [NUM_W-1:0] dq,
    input logic [DEN_W-1:0] d
  );
    logic [DEN_W+1:0] trial;
    logic [DEN_W:0]   r;
    logic [NUM_W-1:0] q;
    r = rem;
    q = dq;
    for (int b = 0; b < BPS; b++) begin
      trial = {r, q[NUM_W-1]};
      q     = {q[NUM_W-2:0], 1'b0};
      if (trial >= {2'b00, d}) begin
        trial = trial - {2'b00, d};
        q[0]  = 1'b1;
      end
      r = trial[DEN_W:0];
    end
    return {r, q};
  endfunction

  always_comb begin
    rem_in[0] = '0;
    dq_in[0]  = num;
    den_in[0] = den;
    neg_i[0]  = neg_in;
    tag_i[0]  = tag_in;
    for (int s = 1; s < STAGES; s++) begin
      rem_in[s] = rem_q[s-1];
      dq_in[s]  = dq_q[s-1];
      den_in[s] = den_q[s-1];
      neg_i[s]  = neg_q[s-1];
      tag_i[s]  = tag_q[s-1];
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < STAGES; s++) begin
      if (en[s]) begin
        {rem_q[s], dq_q[s]} <= div_step(rem_in[s], dq_in[s], den_in[s]);
        den_q[s] <= den_in[s];
        neg_q[s] <= neg_i[s];
        tag_q[s] <= tag_i[s];
      end
    end
  end

  assign quo     = dq_q[STAGES-1];
  assign neg_out = neg_q[STAGES-1];
  assign tag_out = tag_q[STAGES-1];

endmodule

// ===== sv/fan_curve_interpolator_unit.sv =====
// Top level of the fan curve interpolator: registers, curve sort and result pipeline.
//
//   channel   signals                               direction
//   cfg       cfg_valid cfg_ready cfg_index cfg_data  write in
//   in        in_valid in_ready temperature            item in
//   out       out_valid out_ready fan_percent          result out
//
// Ten register stages: clamp, compare, segment pick, differences, product, four divider
// stages of four quotient bits each, and the output register. One item per cycle while
// out_ready does not stall the pipe and no re-sort is running.
// After reset and after every register write the curve is re-sorted; in_ready stays
// low meanwhile.
// A stall at out_ready holds the last stage; earlier stages still fill empty slots.
`include "fan_curve_interpolator_unit_defines.svh"

module fan_curve_interpolator_unit import fci_pkg::*; #(
  parameter int CURVE_POINTS = CURVE_POINTS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [POINT_W-1:0]   cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [TEMP_IN_W-1:0] temperature,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [PCT_W-1:0]     fan_percent
);

  localparam int CNT_W      = $clog2(CURVE_POINTS+1);
  localparam int DIV_STAGES = DIV_NUM_W / DIV_BPS;
  localparam int S_DIV0     = 5;
  localparam int NSTG       = S_DIV0 + DIV_STAGES + 1;

  typedef struct packed {
    logic                 direct;
    logic [PT_TEMP_W-1:0] tc;
    logic [PT_TEMP_W-1:0] lt;
    logic [PT_TEMP_W-1:0] rt;
    logic [PCT_W-1:0]     lp;
    logic [PCT_W-1:0]     rp;
  } sel_t;

  typedef struct packed {
    logic                 direct;
    logic [PCT_W-1:0]     lp;
    logic [PT_TEMP_W-1:0] off;
    logic [DIV_DEN_W-1:0] span;
    logic signed [7:0]    dp;
  } diff_t;

  logic [POINT_W-1:0] point_q [NUM_REGS];
  logic               cfg_fire;
  logic               in_fire;

  curve_pt_t          pts [CURVE_POINTS];
  logic [CNT_W-1:0]   sort_cnt;
  logic               sort_busy;
  curve_pt_t          last_pt;
  logic               sorted_ok;

  logic [NSTG-1:0]    v;
  logic [NSTG-1:0]    en;

  logic [PT_TEMP_W-1:0] s0_tc;
  logic [PT_TEMP_W-1:0] s0_tc_next;
  logic [PT_TEMP_W-1:0] s1_tc;
  logic [CURVE_POINTS-1:0] s1_le;
  logic [CURVE_POINTS-1:0] s1_le_next;
  logic               s1_ge_last;
  sel_t               s2;
  sel_t               s2_next;
  curve_pt_t          seg_left;
  curve_pt_t          seg_right;
  diff_t              s3;
  diff_t              s3_next;

  logic signed [DIV_NUM_W-1:0] prod;
  logic signed [DIV_NUM_W-1:0] num;
  logic [DIV_NUM_W-1:0]        s4_mag;
  logic                        s4_neg;
  logic [DIV_DEN_W-1:0]        s4_den;
  div_tag_t                    s4_tag;

  logic [DIV_NUM_W-1:0]        dv_quo;
  logic                        dv_neg;
  div_tag_t                    dv_tag;
  logic signed [DIV_NUM_W+1:0] qs;
  logic signed [DIV_NUM_W+1:0] vsum;
  logic [PCT_W-1:0]            fan_percent_next;

  // Configuration registers.
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      point_q <= POINT_RESET;
    end else if (cfg_fire) begin
      point_q[cfg_index] <= cfg_data;
    end
  end

  fci_sorter #(.CURVE_POINTS(CURVE_POINTS)) u_sorter (
    .clk    (clk),
    .rst    (rst),
    .start  (cfg_fire),
    .points (point_q),
    .pts    (pts),
    .cnt    (sort_cnt),
    .busy   (sort_busy)
  );

  always_comb begin
    last_pt   = '0;
    sorted_ok = 1'b1;
    for (int k = 0; k < CURVE_POINTS; k++) begin
      if (CNT_W'(k + 1) == sort_cnt) last_pt = pts[k];
    end
    for (int k = 0; k < CURVE_POINTS - 1; k++) begin
      if ((CNT_W'(k + 1) < sort_cnt) && (pts[k].temp > pts[k+1].temp)) sorted_ok = 1'b0;
    end
  end

  // Stage enables: a stage moves when it is empty or the one after it moves.
  always_comb begin
    en[NSTG-1] = !v[NSTG-1] || out_ready;
    for (int s = NSTG - 2; s >= 0; s--) en[s] = !v[s] || en[s+1];
  end

  assign in_ready  = en[0] && !sort_busy;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = v[NSTG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= in_fire;
      for (int s = 1; s < NSTG; s++) begin
        if (en[s]) v[s] <= v[s-1];
      end
    end
  end

  // Stage 0: clamp the sample to 0..100.
  always_comb begin
    if (temperature[TEMP_IN_W-1]) begin
      s0_tc_next = '0;
    end else if (temperature[7:0] > {1'b0, TEMP_MAX}) begin
      s0_tc_next = TEMP_MAX;
    end else begin
      s0_tc_next = temperature[PT_TEMP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) s0_tc <= s0_tc_next;
  end

  // Stage 1: compare against every sorted point.
  always_comb begin
    for (int k = 0; k < CURVE_POINTS; k++) s1_le_next[k] = (s0_tc <= pts[k].temp);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_tc      <= s0_tc;
      s1_le      <= s1_le_next;
      s1_ge_last <= (s0_tc >= last_pt.temp);
    end
  end

  // Stage 2: pick the end cases or the first segment whose right end reaches the sample.
  always_comb begin
    seg_left  = '0;
    seg_right = '0;
    for (int k = 1; k < CURVE_POINTS; k++) begin
      if (s1_le[k] && !s1_le[k-1] && (CNT_W'(k) < sort_cnt)) begin
        seg_left  = seg_left | pts[k-1];
        seg_right = seg_right | pts[k];
      end
    end
    s2_next        = '0;
    s2_next.tc     = s1_tc;
    s2_next.direct = 1'b1;
    if (sort_cnt == '0) begin
      s2_next.lp = '0;
    end else if ((sort_cnt == CNT_W'(1)) || s1_le[0]) begin
      s2_next.lp = pts[0].pct;
    end else if (s1_ge_last) begin
      s2_next.lp = last_pt.pct;
    end else begin
      s2_next.direct = 1'b0;
      s2_next.lt     = seg_left.temp;
      s2_next.rt     = seg_right.temp;
      s2_next.lp     = seg_left.pct;
      s2_next.rp     = seg_right.pct;
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) s2 <= s2_next;
  end

  // Stage 3: offset, span and rise of the segment.
  always_comb begin
    s3_next.direct = s2.direct;
    s3_next.lp     = s2.lp;
    s3_next.off    = s2.tc - s2.lt;
    s3_next.span   = s2.rt - s2.lt;
    s3_next.dp     = $signed({1'b0, s2.rp}) - $signed({1'b0, s2.lp});
  end

  always_ff @(posedge clk) begin
    if (en[3]) s3 <= s3_next;
  end

  // Stage 4: product plus half span, split into sign and magnitude.
  always_comb begin
    prod = $signed({1'b0, s3.off}) * s3.dp;
    num  = prod + $signed({{(DIV_NUM_W-DIV_DEN_W+1){1'b0}}, s3.span[DIV_DEN_W-1:1]});
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_neg <= num[DIV_NUM_W-1];
      s4_mag <= num[DIV_NUM_W-1] ? DIV_NUM_W'(-num) : DIV_NUM_W'(num);
      s4_den <= s3.span;
      s4_tag <= '{direct: s3.direct, lp: s3.lp};
    end
  end

  fci_div_pipe #(
    .NUM_W (DIV_NUM_W),
    .DEN_W (DIV_DEN_W),
    .BPS   (DIV_BPS)
  ) u_div (
    .clk     (clk),
    .en      (en[S_DIV0 +: DIV_STAGES]),
    .num     (s4_mag),
    .den     (s4_den),
    .neg_in  (s4_neg),
    .tag_in  (s4_tag),
    .quo     (dv_quo),
    .neg_out (dv_neg),
    .tag_out (dv_tag)
  );

  // Last stage: restore the sign (truncating toward zero), add the left percent, clamp.
  always_comb begin
    qs = dv_neg ? -$signed({2'b00, dv_quo}) : $signed({2'b00, dv_quo});
    if (dv_tag.direct) begin
      vsum = $signed({{(DIV_NUM_W-PCT_W+2){1'b0}}, dv_tag.lp});
    end else begin
      vsum = qs + $signed({{(DIV_NUM_W-PCT_W+2){1'b0}}, dv_tag.lp});
    end
    if (vsum < 0) begin
      fan_percent_next = '0;
    end else if (vsum > $signed({{(DIV_NUM_W-PCT_W+2){1'b0}}, PCT_MAX})) begin
      fan_percent_next = PCT_MAX;
    end else begin
      fan_percent_next = vsum[PCT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[NSTG-1]) fan_percent <= fan_percent_next;
  end

  `FCI_ASSERT_IMPL(a_pct_range, out_valid, fan_percent <= PCT_MAX, "fan_percent above full scale")
  `FCI_ASSERT_NEXT(a_cfg_blocks_input, cfg_valid && cfg_ready, !in_ready, "input open during re-sort")
  `FCI_ASSERT_IMPL(a_curve_sorted, $fell(sort_busy), sorted_ok, "curve not ascending after sort")

endmodule
